FILE: hw/rtl/s2d_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package s2d_pkg;

  localparam int VALUE_W   = 32;
  localparam int PORT_W    = 8;
  localparam int CHAR_W    = 8;
  localparam int BIT_CNT_W = 5;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PORT_W-1:0]         port;
  } in_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

endpackage

FILE: hw/rtl/s2d_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module s2d_dabble #(
  parameter int NDIG = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [s2d_pkg::VALUE_W-1:0]     mag,
  output logic                            done,
  output logic [4*NDIG-1:0]               bcd,
  output logic                            ovf
);

  logic [s2d_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [4*NDIG-1:0]             bcd_r, bcd_nxt;
  logic [4*NDIG-1:0]             corr;
  logic                          ovf_r, ovf_nxt;
  logic [s2d_pkg::BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      corr[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {corr[4*NDIG-2:0], mag_r[s2d_pkg::VALUE_W-1]};
      ovf_nxt = ovf_r | corr[4*NDIG-1];
      mag_nxt = {mag_r[s2d_pkg::VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == s2d_pkg::BIT_CNT_W'(s2d_pkg::VALUE_W-1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;
  assign ovf  = ovf_r;

endmodule

FILE: hw/rtl/s2d_emit.sv
// Character emitter: sign, then BCD digits one per cycle with leading zero suppression.
module s2d_emit #(
  parameter int NDIG = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [4*NDIG-1:0]             bcd,
  input  logic                          ovf,
  input  logic                          neg,
  input  logic [s2d_pkg::PORT_W-1:0]    port,
  output logic                          fin,
  output logic                          out_valid,
  output s2d_pkg::out_t                 out_data
);

  localparam int CW = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic                        act_r, act_nxt;
  logic                        minus_r, minus_nxt;
  logic                        lead_r, lead_nxt;
  logic [4*NDIG-1:0]           dig_r, dig_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [s2d_pkg::PORT_W-1:0]  port_r, port_nxt;
  logic                        val_r, val_nxt;
  s2d_pkg::out_t               data_r, data_nxt;
  logic [3:0]                  top;
  logic                        is_last;

  assign top     = dig_r[4*NDIG-1 -: 4];
  assign is_last = (cnt_r == '0);

  always_comb begin
    act_nxt   = act_r;
    minus_nxt = minus_r;
    lead_nxt  = lead_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    port_nxt  = port_r;
    val_nxt   = 1'b0;
    data_nxt  = data_r;
    fin       = 1'b0;
    if (load) begin
      act_nxt   = 1'b1;
      minus_nxt = neg;
      lead_nxt  = ~ovf;
      dig_nxt   = bcd;
      cnt_nxt   = CW'(NDIG-1);
      port_nxt  = port;
    end else if (act_r) begin
      if (minus_r) begin
        minus_nxt          = 1'b0;
        val_nxt            = 1'b1;
        data_nxt.out_port  = port_r;
        data_nxt.character = s2d_pkg::CHAR_MINUS;
        data_nxt.last      = 1'b0;
      end else begin
        if (!(lead_r && top == 4'd0 && !is_last)) begin
          lead_nxt           = 1'b0;
          val_nxt            = 1'b1;
          data_nxt.out_port  = port_r;
          data_nxt.character = s2d_pkg::CHAR_ZERO + {4'd0, top};
          data_nxt.last      = is_last;
        end
        dig_nxt = dig_r << 4;
        cnt_nxt = cnt_r - 1'b1;
        if (is_last) begin
          act_nxt = 1'b0;
          fin     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      val_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      val_r <= val_nxt;
    end
    minus_r <= minus_nxt;
    lead_r  <= lead_nxt;
    dig_r   <= dig_nxt;
    cnt_r   <= cnt_nxt;
    port_r  <= port_nxt;
    data_r  <= data_nxt;
  end

  assign out_valid = val_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//   channel | handshake          | payload
//   in      | start, busy        | in_data  (value, port)
//   out     | out_valid (strobe) | out_data (out_port, character, last)
//
// After acceptance an item goes through the bit-serial BCD shift, then the emitter
// puts out the minus sign if the value is negative and walks one digit per cycle,
// suppressed leading zeros included.
// Synchronous active-low reset clears all control state; no item is in flight after it.
// busy stays high from acceptance until the last character is registered.
// out_valid lasts one cycle per character; the receiver cannot stall.
module signed_int_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  s2d_pkg::in_t   in_data,
  output logic           out_valid,
  output s2d_pkg::out_t  out_data
);

  logic                         busy_r, busy_nxt;
  logic                         neg_r;
  logic [s2d_pkg::PORT_W-1:0]   port_r;
  logic                         accept;
  logic [s2d_pkg::VALUE_W-1:0]  raw;
  logic [s2d_pkg::VALUE_W-1:0]  mag;
  logic                         conv_done;
  logic [4*MAX_DIGITS-1:0]      bcd;
  logic                         ovf;
  logic                         fin;

  assign accept = start & ~busy_r;
  assign raw    = in_data.value;
  assign mag    = raw[s2d_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    if (accept) begin
      neg_r  <= raw[s2d_pkg::VALUE_W-1];
      port_r <= in_data.port;
    end
  end

  s2d_dabble #(.NDIG(MAX_DIGITS)) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd),
    .ovf   (ovf)
  );

  s2d_emit #(.NDIG(MAX_DIGITS)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (conv_done),
    .bcd       (bcd),
    .ovf       (ovf),
    .neg       (neg_r),
    .port      (port_r),
    .fin       (fin),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = busy_r;

endmodule

FILE: dv/ascii_run_checker.sv
`timescale 1ns / 100ps
// Checker for the decimal ASCII converter: predicts each character run and compares it.
module ascii_run_checker #(
  parameter int MAX_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  s2d_pkg::in_t  in_data,
  input  logic          out_valid,
  input  s2d_pkg::out_t out_data,
  output int            chars_owed,
  output int            mismatch_cnt
);

  localparam int unsigned RADIX = 10;

  s2d_pkg::out_t owed_q[$];
  int            errs = 0;

  function automatic void predict_ascii_run(s2d_pkg::in_t item);
    logic [s2d_pkg::VALUE_W-1:0] mag;
    logic [3:0]                  digit [MAX_DIGITS];
    int                          n;
    bit                          neg;
    s2d_pkg::out_t               ch;
    neg = item.value[s2d_pkg::VALUE_W-1];
    mag = item.value;
    if (neg) mag = ~mag + 32'd1;
    n = 0;
    ch.out_port = item.port;
    if (neg) begin
      ch.character = s2d_pkg::CHAR_MINUS;
      ch.last = 1'b0;
      owed_q.push_back(ch);
    end
    if (mag == 0) begin
      ch.character = s2d_pkg::CHAR_ZERO;
      ch.last = 1'b1;
      owed_q.push_back(ch);
      return;
    end
    // only the low MAX_DIGITS digits survive if the buffer is short
    while (mag != 0 && n < MAX_DIGITS) begin
      digit[n] = 4'(mag % RADIX);
      mag = mag / RADIX;
      n++;
    end
    for (int i = n; i > 0; i--) begin
      ch.character = s2d_pkg::CHAR_ZERO + digit[i-1];
      ch.last = (i == 1);
      owed_q.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    s2d_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected character port=%h char=%h last=%b", $realtime,
                     out_data.out_port, out_data.character, out_data.last);
        end else begin
          want = owed_q.pop_front();
          if (out_data.out_port !== want.out_port || out_data.character !== want.character ||
              out_data.last !== want.last) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch exp port=%h char=%h last=%b, got port=%h char=%h last=%b",
                       $realtime, want.out_port, want.character, want.last,
                       out_data.out_port, out_data.character, out_data.last);
          end
        end
      end
      if (start && !busy) predict_ascii_run(in_data);
    end
    chars_owed   <= owed_q.size();
    mismatch_cnt <= errs;
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the decimal ASCII converter: stimulus, pacing and verdict.
module tb_top;

  logic          clk   = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  s2d_pkg::in_t  in_data = '0;
  logic          out_valid;
  s2d_pkg::out_t out_data;
  int            chars_owed;
  int            mismatch_cnt;
  int            burst_left = 0;

  always #2 clk = ~clk;

  signed_int_to_decimal_ascii #(.MAX_DIGITS(10)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  ascii_run_checker #(.MAX_DIGITS(10)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .chars_owed  (chars_owed),
    .mismatch_cnt(mismatch_cnt)
  );

  task automatic send_item(input logic signed [31:0] v, input logic [7:0] p);
    start   <= 1'b1;
    in_data <= '{value: v, port: p};
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // n must be at least 1 so start is never lowered and raised in one step
  task automatic idle_gap(input int n);
    start   <= 1'b0;
    in_data <= '{value: $urandom, port: 8'($urandom_range(0, 255))};
    repeat (n) @(posedge clk);
  endtask

  task automatic send_paced(input logic signed [31:0] v, input logic [7:0] p);
    if (burst_left == 0) begin
      idle_gap($urandom_range(1, 15));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    end
    burst_left--;
    send_item(v, p);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (chars_owed != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // mostly values of a chosen digit count, so short and long runs both occur
  function automatic logic signed [31:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    bit     neg;
    if ($urandom_range(0, 4) == 0) return $urandom;
    nd  = $urandom_range(1, 10);
    neg = $urandom_range(0, 1);
    hi  = 1;
    repeat (nd) hi = hi * 10;
    lo  = (nd == 1) ? 0 : hi / 10;
    hi  = hi - 1;
    if (nd == 10) hi = neg ? 64'd2147483648 : 64'd2147483647;
    mag = lo + ($urandom % (hi - lo + 1));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  initial begin
    logic signed [31:0] dir_val [20];
    logic [7:0]         dir_port [20];
    dir_val = '{0, 0, -1, 1, 9, 10, -10, 99, 100, 2147483647,
                32'sh80000000, -2147483647, 1000000000, 999999999, -999999999,
                32'h55555555, 32'hAAAAAAAA, 1234567890, -2000000000, 7};
    dir_port = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'h12, 8'hFE, 8'hFF,
                 8'h00, 8'hC3, 8'h3C, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h42, 8'h99, 8'h00};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_val[i]) send_paced(dir_val[i], dir_port[i]);
    wait_drained();
    repeat (50) send_paced(random_value(), 8'($urandom_range(0, 255)));
    wait_drained();
    repeat (50) send_paced(random_value(), 8'($urandom_range(0, 255)));
    wait_drained();
    repeat (60) @(posedge clk);
    if (chars_owed != 0)
      $display("%0d expected characters never arrived", chars_owed);
    if (mismatch_cnt == 0 && chars_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
